// ----- rtl/converter_duty_regulator_macros.svh -----
// Assertion macros used by the converter duty regulator top level.
`ifndef CONVERTER_DUTY_REGULATOR_MACROS_SVH
`define CONVERTER_DUTY_REGULATOR_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset.
`define CDR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CDR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CDR_ASSERT(label, clk, rst, prop, msg)
`define CDR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/cdr_pkg.sv -----
// Types, constants and helper functions of the converter duty regulator.
package cdr_pkg;

   localparam logic [11:0] CtrlMax   = 12'd3200;
   localparam logic [11:0] CtrlMin   = 12'd800;
   localparam logic [11:0] TargetMin = 12'd2100;
   localparam logic [11:0] TargetMax = 12'd2800;
   localparam logic [11:0] JumpVal   = 12'd2550;
   localparam logic [11:0] TargetRst = 12'd2100;
   localparam logic [9:0]  StepCap   = 10'd160;
   localparam logic signed [13:0] JumpErr   = 14'sd200;
   localparam logic signed [13:0] StartStep = 14'sd10;
   localparam logic [5:0]  VoltScale = 6'd45;

   localparam int unsigned CsrAddrW = 3;
   localparam logic        RegTargetVoltage = 1'b0;

   typedef struct packed {
      logic       start_phase;
      logic       run_enable;
      logic [9:0] current_b;
      logic [9:0] current_a;
      logic [9:0] voltage_sample;
   } item_type;

   typedef struct packed {
      logic [7:0]  current_sum;
      logic [11:0] measured_voltage;
      logic [11:0] control_value;
      logic [11:0] duty;
   } result_type;

   typedef struct packed {
      logic [11:0] last_voltage;
      logic [11:0] control;
      logic [7:0]  current_sum;
      logic [9:0]  current_offset;
   } state_type;

   // Magnitude of a signed value divided by 16, limited to the step cap.
   // For negative values ~x equals -x-1.
   function automatic logic [7:0] mag16(input logic signed [13:0] x);
      logic [13:0] m;
      logic [9:0]  q;
      m = x[13] ? ~x : x;
      q = m[13:4];
      return (q > StepCap) ? StepCap[7:0] : q[7:0];
   endfunction

   // Hysteresis staircase of the current offset; earlier rules win.
   function automatic logic [9:0] next_offset(input logic [9:0] o, input logic [7:0] s);
      logic [9:0] r;
      r = o;
      priority if (o != 10'd400 && s >= 8'd100) r = 10'd600;
      else if (s >= 8'd105) r = 10'd600;
      else if (o != 10'd600 && o != 10'd300 && s < 8'd100 && s >= 8'd90) r = 10'd400;
      else if (o == 10'd600 && s <= 8'd95 && s >= 8'd90) r = 10'd400;
      else if (o == 10'd300 && s >= 8'd95 && s < 8'd100) r = 10'd400;
      else if (o != 10'd400 && o != 10'd200 && s < 8'd90 && s >= 8'd80) r = 10'd300;
      else if (o == 10'd400 && s <= 8'd85 && s >= 8'd80) r = 10'd300;
      else if (o == 10'd200 && s >= 8'd85 && s < 8'd90) r = 10'd300;
      else if (o != 10'd300 && o != 10'd150 && s < 8'd80 && s >= 8'd70) r = 10'd200;
      else if (o == 10'd300 && s <= 8'd75 && s >= 8'd70) r = 10'd200;
      else if (o == 10'd150 && s >= 8'd75 && s < 8'd80) r = 10'd200;
      else if (o != 10'd200 && o != 10'd100 && s < 8'd70 && s >= 8'd60) r = 10'd150;
      else if (o == 10'd200 && s <= 8'd65 && s >= 8'd60) r = 10'd150;
      else if (o == 10'd100 && s >= 8'd65 && s < 8'd70) r = 10'd150;
      else if (o != 10'd150 && o != 10'd80 && s < 8'd60 && s >= 8'd50) r = 10'd100;
      else if (o == 10'd150 && s <= 8'd55 && s >= 8'd50) r = 10'd100;
      else if (o == 10'd80 && s >= 8'd55 && s < 8'd60) r = 10'd100;
      else if (o != 10'd100 && o != 10'd60 && s < 8'd50 && s >= 8'd40) r = 10'd80;
      else if (o == 10'd100 && s <= 8'd45 && s >= 8'd40) r = 10'd80;
      else if (o == 10'd60 && s >= 8'd45 && s < 8'd50) r = 10'd80;
      else if (o != 10'd80 && o != 10'd40 && s < 8'd40 && s >= 8'd30) r = 10'd60;
      else if (o == 10'd80 && s <= 8'd35 && s >= 8'd30) r = 10'd60;
      else if (o == 10'd40 && s >= 8'd35 && s < 8'd40) r = 10'd60;
      else if (o != 10'd60 && o != 10'd20 && s < 8'd30 && s >= 8'd20) r = 10'd40;
      else if (o == 10'd60 && s <= 8'd25 && s >= 8'd20) r = 10'd40;
      else if (o == 10'd20 && s >= 8'd25 && s < 8'd30) r = 10'd40;
      else if (o != 10'd40 && o != 10'd0 && s < 8'd20 && s >= 8'd10) r = 10'd20;
      else if (o == 10'd40 && s <= 8'd15 && s >= 8'd10) r = 10'd20;
      else if (o == 10'd0 && s >= 8'd15 && s < 8'd20) r = 10'd20;
      else if (o != 10'd20 && s < 8'd10) r = 10'd0;
      else if (o == 10'd20 && s <= 8'd5) r = 10'd0;
      else r = o;
      return r;
   endfunction

endpackage

// ----- rtl/cdr_core.sv -----
// Regulation arithmetic: one measurement word and the loop state give the result and next state.
module cdr_core import cdr_pkg::*; (
   input  item_type    item,
   input  state_type   state,
   input  logic [11:0] target_voltage,
   output state_type   state_in,
   output result_type  result
);

   logic [15:0]        volt_prod;
   logic [11:0]        volt;
   logic [11:0]        target_sat;
   logic [12:0]        setpoint;
   logic signed [13:0] err;
   logic signed [13:0] diff;
   logic [7:0]         prop_mag;
   logic [7:0]         diff_mag;
   logic signed [13:0] acc;
   logic [11:0]        ctrl;
   logic [11:0]        duty;
   logic [10:0]        cur_total;
   logic [7:0]         cur_sum;

   assign volt_prod = {6'b0, item.voltage_sample} * {10'b0, VoltScale};
   assign volt      = volt_prod[15:4];

   always_comb begin
      if (target_voltage < TargetMin) begin
         target_sat = TargetMin;
      end else if (target_voltage > TargetMax) begin
         target_sat = TargetMax;
      end else begin
         target_sat = target_voltage;
      end
   end

   // The previous current sum raises the target to cover cable drop.
   assign setpoint = {1'b0, target_sat} + {5'b0, state.current_sum};
   assign err      = $signed({2'b0, volt}) - $signed({1'b0, setpoint});
   assign diff     = $signed({2'b0, volt}) - $signed({2'b0, state.last_voltage});
   assign prop_mag = mag16(err);
   assign diff_mag = mag16(diff);

   always_comb begin
      acc = $signed({2'b0, state.control});
      if (item.start_phase) begin
         acc = err[13] ? acc - StartStep : acc + StartStep;
      end else if (err > JumpErr && state.control < JumpVal) begin
         acc = $signed({2'b0, JumpVal});
      end else begin
         acc = err[13] ? acc - $signed({6'b0, prop_mag}) : acc + $signed({6'b0, prop_mag});
         if (diff > 14'sd0) begin
            acc = acc + $signed({6'b0, diff_mag});
         end else if (diff < 14'sd0) begin
            acc = acc - $signed({6'b0, diff_mag});
         end
      end
   end

   always_comb begin
      if (!item.run_enable) begin
         ctrl = CtrlMax;
         duty = CtrlMax;
      end else begin
         if (acc > $signed({2'b0, CtrlMax})) begin
            ctrl = CtrlMax;
         end else if (acc < $signed({2'b0, CtrlMin})) begin
            ctrl = CtrlMin;
         end else begin
            ctrl = acc[11:0];
         end
         // An offset larger than the control value is ignored.
         if (ctrl >= {2'b0, state.current_offset}) begin
            duty = ctrl - {2'b0, state.current_offset};
         end else begin
            duty = ctrl;
         end
      end
   end

   assign cur_total = {1'b0, item.current_a} + {1'b0, item.current_b};
   assign cur_sum   = cur_total[10:3];

   assign state_in.last_voltage   = volt;
   assign state_in.control        = ctrl;
   assign state_in.current_sum    = cur_sum;
   assign state_in.current_offset = next_offset(state.current_offset, cur_sum);

   assign result.duty             = duty;
   assign result.control_value    = ctrl;
   assign result.measured_voltage = volt;
   assign result.current_sum      = cur_sum;

endmodule

// ----- rtl/converter_duty_regulator.sv -----
// Top level of the converter duty regulator: stream ports, loop state and setpoint register.
//
// Regulates a PWM converter from finished measurement sets. Each word on the req_ stream
// carries one voltage sample, two current samples and the run and start flags; each word on
// the rsp_ stream carries the duty, the control value, the scaled voltage and the current sum
// for that set. A word is taken into an input register, worked by the combinational
// regulation arithmetic, and lands in the result register while the loop state is updated,
// so one word is accepted every cycle while the rsp_ side takes results, and its result is
// presented from the result register, to be taken at the next edge at which the rsp_ side
// is ready. The combinational loop from the state registers through the error, step and
// clamp logic back to the state sets that rate. The setpoint lies at byte address 0 of the
// csr_ port, is used saturated to 2100..2800 and must be written while the block is idle.
`include "converter_duty_regulator_macros.svh"

module converter_duty_regulator import cdr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // voltage_sample[9:0], current_a[19:10], current_b[29:20], zero fill[31:30]
   input  logic [31:0]         req_tdata,
   // run_enable[0], start_phase[1]
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // duty[11:0], control_value[23:12], measured_voltage[35:24], current_sum[43:36],
   // zero fill[47:44]
   output logic [47:0]         rsp_tdata,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   item_type    item_ff;
   logic        item_valid_ff;
   result_type  rsp_ff;
   logic        rsp_valid_ff;
   state_type   state_ff;
   state_type   state_in;
   result_type  result_in;
   logic [11:0] target_ff;
   logic        rsp_load;
   logic        req_take;
   logic        csr_write;

   // The result register loads a held word when empty or when its word is being taken.
   assign rsp_load   = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || rsp_load;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.voltage_sample <= req_tdata[9:0];
         item_ff.current_a      <= req_tdata[19:10];
         item_ff.current_b      <= req_tdata[29:20];
         item_ff.run_enable     <= req_tuser[0];
         item_ff.start_phase    <= req_tuser[1];
      end
   end

   cdr_core u_core (
      .item           (item_ff),
      .state          (state_ff),
      .target_voltage (target_ff),
      .state_in       (state_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_voltage   <= 12'd0;
         state_ff.control        <= CtrlMax;
         state_ff.current_sum    <= 8'd0;
         state_ff.current_offset <= 10'd0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (rsp_load) begin
            state_ff <= state_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff};

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TargetRst;
      end else if (csr_write && csr_paddr[CsrAddrW-1] == RegTargetVoltage) begin
         target_ff <= csr_pwdata[11:0];
      end
   end

   always_comb begin
      if (csr_paddr[CsrAddrW-1] == RegTargetVoltage) begin
         csr_prdata = {20'b0, target_ff};
      end else begin
         csr_prdata = 32'b0;
      end
   end

   `CDR_ASSERT(a_ctrl_range, clock, reset,
      rsp_valid_ff |-> (rsp_ff.control_value >= CtrlMin && rsp_ff.control_value <= CtrlMax),
      "control value outside its clamp range")
   `CDR_ASSERT(a_duty_le_ctrl, clock, reset,
      rsp_valid_ff |-> (rsp_ff.duty <= rsp_ff.control_value),
      "duty above control value")
   `CDR_ASSERT(a_state_hold, clock, reset,
      !rsp_load |=> $stable(state_ff),
      "loop state changed without a word moving on")
   `CDR_ASSERT(a_stopped_duty, clock, reset,
      (rsp_load && !item_ff.run_enable) |=>
         (rsp_ff.duty == CtrlMax && rsp_ff.control_value == CtrlMax),
      "stopped converter not driven to full value")
   `CDR_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> (!item_valid_ff && !rsp_valid_ff),
      "pipeline not empty after reset")

endmodule

// ----- tb/converter_duty_regulator_tb.sv -----
// Self-checking testbench of the converter duty regulator: directed and random measurement sets.
module converter_duty_regulator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cdr_pkg::*;

   localparam int CtrlCeiling  = 3200;
   localparam int CtrlFloor    = 800;
   localparam int SetpointLow  = 2100;
   localparam int SetpointHigh = 2800;
   localparam int StepLimit    = 160;
   localparam int JumpError    = 200;
   localparam int JumpLevel    = 2550;
   localparam int SoftStep     = 10;
   localparam int VoltGain     = 45;
   localparam int StallLimit   = 1000;
   localparam int SettleCycles = 4;
   localparam int OffsetLevels [0:10] = '{0, 20, 40, 60, 80, 100, 150, 200, 300, 400, 600};

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata   = '0;
   logic [1:0]          req_tuser   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [47:0]         rsp_tdata;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr   = '0;
   logic [31:0]         csr_pwdata  = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // Regulator state as the block should hold it.
   logic [11:0] setpoint_word = 12'd2100;
   logic [11:0] prev_volt     = '0;
   logic [11:0] ctrl_level    = 12'd3200;
   logic [7:0]  prev_sum      = '0;
   logic [9:0]  offset_level  = '0;

   result_type expected_words[$];
   int error_count    = 0;
   int send_gap_max   = 0;
   int recv_stall_max = 0;
   int idle_cycles    = 0;

   converter_duty_regulator uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int effective_setpoint();
      int t;
      t = int'(setpoint_word);
      if (t < SetpointLow) t = SetpointLow;
      if (t > SetpointHigh) t = SetpointHigh;
      return t;
   endfunction

   function automatic int step_size(input int x);
      int m;
      m = (x >= 0) ? (x >>> 4) : ((-x - 1) >>> 4);
      return (m > StepLimit) ? StepLimit : m;
   endfunction

   // Each band of ten in the current sum has its own level. The level just above a band is
   // kept down to the middle of the band, and the level just below it is kept up to the middle.
   function automatic logic [9:0] offset_after(input logic [9:0] o, input logic [7:0] s);
      int band, pos, here, above, below;
      if (s >= 100) return (o == OffsetLevels[9] && s < 105) ? o : 10'(OffsetLevels[10]);
      band  = s / 10;
      pos   = s % 10;
      here  = OffsetLevels[band];
      above = OffsetLevels[band + 1];
      below = (band > 0) ? OffsetLevels[band - 1] : -1;
      if (o == above) return (pos <= 5) ? 10'(here) : o;
      if (o == below) return (pos >= 5) ? 10'(here) : o;
      return 10'(here);
   endfunction

   function automatic result_type regulate_reading(input item_type it);
      result_type r;
      int volt, err, acc, dv, duty;
      volt = (int'(it.voltage_sample) * VoltGain) >>> 4;
      err  = volt - (effective_setpoint() + int'(prev_sum));
      acc  = int'(ctrl_level);
      if (it.run_enable) begin
         if (it.start_phase) begin
            acc += (err >= 0) ? SoftStep : -SoftStep;
         end else if (err > JumpError && acc < JumpLevel) begin
            acc = JumpLevel;
         end else begin
            acc += (err >= 0) ? step_size(err) : -step_size(err);
            dv = volt - int'(prev_volt);
            if (dv > 0) acc += step_size(dv);
            else if (dv < 0) acc -= step_size(dv);
         end
         if (acc > CtrlCeiling) acc = CtrlCeiling;
         if (acc < CtrlFloor) acc = CtrlFloor;
         // The offset in use is the one left by the previous word.
         duty = (acc >= int'(offset_level)) ? acc - int'(offset_level) : acc;
      end else begin
         acc  = CtrlCeiling;
         duty = CtrlCeiling;
      end
      ctrl_level   = 12'(acc);
      prev_volt    = 12'(volt);
      prev_sum     = 8'((int'(it.current_a) + int'(it.current_b)) >>> 3);
      offset_level = offset_after(offset_level, prev_sum);
      r.duty             = 12'(duty);
      r.control_value    = ctrl_level;
      r.measured_voltage = prev_volt;
      r.current_sum      = prev_sum;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_reading(input item_type it);
      int gap;
      gap = $urandom_range(send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, it.current_b, it.current_a, it.voltage_sample};
      req_tuser  <= {it.start_phase, it.run_enable};
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(regulate_reading(it));
   endtask

   task automatic send_set(input int v, input int a, input int b, input bit run,
                           input bit start);
      item_type it;
      it.voltage_sample = 10'(v);
      it.current_a      = 10'(a);
      it.current_b      = 10'(b);
      it.run_enable     = run;
      it.start_phase    = start;
      send_reading(it);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes the setpoint, then reads it straight back.
   task automatic write_setpoint(input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'(4 * RegTargetVoltage);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      setpoint_word = value[11:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      compare_field("target_voltage", 32'(value[11:0]), 32'(csr_prdata[11:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_limits_and_modes();
      send_gap_max   = 2;
      recv_stall_max = 2;
      send_set(1023, 1023, 1023, 0, 1);
      send_set(0, 0, 0, 1, 1);
      send_set(1023, 0, 0, 1, 1);
      // Large error with the control value already above the jump level.
      send_set(1023, 832, 0, 1, 0);
      // Walk the offset staircase up and down across its hysteresis points.
      send_set(0, 768, 0, 1, 0);
      send_set(0, 760, 0, 1, 0);
      send_set(0, 800, 0, 1, 0);
      send_set(0, 840, 0, 1, 0);
      send_set(0, 760, 0, 1, 0);
      send_set(0, 672, 0, 1, 0);
      send_set(0, 712, 0, 1, 0);
      send_set(0, 760, 0, 1, 0);
      send_set(0, 40, 0, 1, 0);
      send_set(0, 120, 0, 1, 0);
      send_set(0, 40, 0, 1, 0);
      send_set(1023, 0, 0, 1, 0);
      send_set(700, 0, 0, 1, 0);
      send_set(760, 0, 0, 1, 0);
      send_set(760, 0, 0, 1, 0);
      send_set(0, 1023, 0, 0, 0);
      send_set(1023, 0, 1023, 1, 0);
   endtask

   task automatic test_regulation(input logic [31:0] setting, input int count,
                                  input int send_gap, input int recv_stall);
      item_type it;
      int sent, seg_len, kind, sum_walk, v, total, ca, k;
      wait_drained();
      write_setpoint(setting);
      send_gap_max   = send_gap;
      recv_stall_max = recv_stall;
      sum_walk = $urandom_range(255);
      sent = 0;
      while (sent < count) begin
         kind    = $urandom_range(9);
         seg_len = $urandom_range(25, 5);
         for (k = 0; k < seg_len && sent < count; k++) begin
            sum_walk += int'($urandom_range(10)) - 5;
            if (sum_walk < 0) sum_walk = 0;
            if (sum_walk > 255) sum_walk = 255;
            total = sum_walk * 8 + int'($urandom_range(7));
            if (total > 2046) total = 2046;
            ca = $urandom_range(total > 1023 ? 1023 : total, total > 1023 ? total - 1023 : 0);
            it.current_a = 10'(ca);
            it.current_b = 10'(total - ca);
            // A voltage close to the point where the loop settles.
            v = (effective_setpoint() + int'(prev_sum)) * 16 / VoltGain
                + int'($urandom_range(24)) - 12;
            it.run_enable  = 1'b1;
            it.start_phase = 1'b0;
            if (kind == 6) begin
               it.start_phase = 1'b1;
               v += int'($urandom_range(120)) - 60;
            end else if (kind == 7) begin
               it.run_enable  = 1'b0;
               it.start_phase = 1'($urandom_range(1));
               v = $urandom_range(1023);
            end else if (kind == 8) begin
               v = $urandom_range(1023);
               it.current_a   = 10'($urandom_range(1023));
               it.current_b   = 10'($urandom_range(1023));
               it.run_enable  = 1'($urandom_range(1));
               it.start_phase = 1'($urandom_range(1));
               sum_walk = $urandom_range(255);
            end else if (kind == 9) begin
               v = ($urandom_range(7) == 0) ? 1023 : int'($urandom_range(300));
            end
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            it.voltage_sample = 10'(v);
            send_reading(it);
            sent++;
         end
      end
   endtask

   initial begin
      int stall;
      forever begin
         stall = $urandom_range(recv_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[43:0]);
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            compare_field("duty", 32'(want.duty), 32'(got.duty));
            compare_field("control_value", 32'(want.control_value),
                          32'(got.control_value));
            compare_field("measured_voltage", 32'(want.measured_voltage),
                          32'(got.measured_voltage));
            compare_field("current_sum", 32'(want.current_sum), 32'(got.current_sum));
            compare_field("zero fill", 0, 32'(rsp_tdata[47:44]));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $error("no word moved for %0d cycles", StallLimit);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_limits_and_modes();
      test_regulation(32'd2800, 130, 9, 9);
      test_regulation(32'd2100, 130, 0, 0);
      test_regulation(32'd0, 130, 9, 0);
      test_regulation(32'hFFF, 130, 0, 9);
      test_regulation(32'hA5A5_0AF0, 130, 9, 9);
      test_regulation($urandom_range(2800, 2100), 130, 3, 3);
      test_regulation($urandom_range(4095), 130, 9, 9);
      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
